[hdl/gauss_newton_peak_fit_3pt_assert.svh]
// Assertion macros for the three-point Gaussian peak fitter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef GAUSS_NEWTON_PEAK_FIT_3PT_ASSERT_SVH
`define GAUSS_NEWTON_PEAK_FIT_3PT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define GNPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define GNPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/gnpf_pkg.sv]
// Shared constants, types and helper functions of the Gaussian peak fitter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gnpf_pkg;

    localparam int POS_FRAC_BITS   = 7;
    localparam int GAIN_FRAC_BITS  = 15;
    localparam int EXP_TABLE_DEPTH = 10;

    // 32768 * 10000, numerator of the inverse variance.
    localparam logic [31:0] RS2_NUM         = 32'd327680000;
    // ceil(2^33 / 3): floor(n / 3) equals (n * this) >> 33 for 32-bit n.
    localparam logic [31:0] ONE_THIRD_RECIP = 32'hAAAAAAAB;
    localparam logic [31:0] EXP_ONE         = 32'd32768;
    localparam logic [31:0] ALL_ONES        = 32'hFFFFFFFF;
    localparam logic signed [31:0] MU_LIMIT    = 32'sd63;
    localparam logic signed [31:0] DPNORM_STOP = 32'sd4;

    localparam logic [6:0] SIGMA_RESET = 7'd50;
    localparam logic [5:0] MAXIT_RESET = 6'd20;

    localparam logic CFG_SIGMA = 1'b0;
    localparam logic CFG_MAXIT = 1'b1;

    typedef struct packed {
        logic start;
        logic axis;
    } lane_ctl_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
        return 32'($signed(x) >>> s);
    endfunction

    // exp(-n) scaled by 2^15; zero outside the table.
    function automatic logic [31:0] exp_tab_at(input logic [31:0] negp);
        logic signed [31:0] idx;
        idx = $signed(negp);
        if (idx < 0 || idx > EXP_TABLE_DEPTH || idx > 16)
            return 32'd0;
        case (negp[4:0])
            5'd0:    return 32'd32768;
            5'd1:    return 32'd12055;
            5'd2:    return 32'd4435;
            5'd3:    return 32'd1631;
            5'd4:    return 32'd600;
            5'd5:    return 32'd221;
            5'd6:    return 32'd81;
            5'd7:    return 32'd30;
            5'd8:    return 32'd11;
            5'd9:    return 32'd4;
            5'd10:   return 32'd1;
            5'd11:   return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

endpackage

[hdl/gauss_newton_peak_fit_3pt.sv]
// Top level of the three-point Gaussian sub-sample peak fitter.
// Depends on gnpf_pkg, gnpf_lane, gnpf_div and the assertion macro header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | input     | in_valid / in_stall  | sample_left/mid/right, center_index
//   out     | output    | out_valid/out_stall  | position, iterations_used
//   cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An item runs I iterations, each a center step then an amplitude step, each step with a
// lane phase and a divide. The 32-step divider, used once per item and twice per
// iteration, takes the largest share of the time that an item spends in the fitter.
// Reset clears the sequencers and restores sigma_hundredths 50 and max_iterations 20.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled output only delays the finish of the following item.
`timescale 1ns / 1ps

module gauss_newton_peak_fit_3pt
    import gnpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] sample_left,
    input  logic signed [15:0] sample_mid,
    input  logic signed [15:0] sample_right,
    input  logic [7:0]         center_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] position,
    output logic [5:0]         iterations_used,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [6:0]         cfg_data
);

    `include "gauss_newton_peak_fit_3pt_assert.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RS2    = 4'd1;
    localparam logic [3:0] S_LSTART = 4'd2;
    localparam logic [3:0] S_LANE   = 4'd3;
    localparam logic [3:0] S_DOT    = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DWAIT  = 4'd6;
    localparam logic [3:0] S_NORM   = 4'd7;
    localparam logic [3:0] S_CHECK  = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0]  state_reg;
    logic [6:0]  sigma_reg;
    logic [5:0]  maxit_reg;
    logic        axis_reg;
    logic [2:0]  cnt_reg;
    logic [2:0]  lane_done_reg;
    logic        out_valid_reg;

    logic [31:0] smp_reg [3];
    logic [7:0]  center_reg;
    logic [31:0] rs2_reg;
    logic [31:0] mu_reg;
    logic [31:0] amp_reg;
    logic [5:0]  iter_reg;
    logic [31:0] dp_reg;
    logic [31:0] dpnorm_reg;
    logic [31:0] jj_reg;
    logic [31:0] jf_reg;
    logic [31:0] mprod_reg;
    logic [15:0] position_reg;
    logic [5:0]  iters_out_reg;

    logic        accept;
    logic        can_load;
    lane_ctl_t   lane_ctl;
    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic [2:0]  lane_done_vec;
    logic [2:0]  lane_done_all;
    logic [31:0] lane_g   [3];
    logic [31:0] lane_jac [3];
    logic [31:0] lane_f   [3];
    logic [13:0] sig_sq;
    logic [31:0] dot_a;
    logic [31:0] dot_b;
    logic [31:0] mprod;
    logic [31:0] mu_sum;
    logic [31:0] mu_clamped;
    logic        div_awaited;
    logic        mu_step_done;
    logic        mu_in_range;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign can_load  = !out_valid_reg || !out_stall;
    assign sig_sq    = sigma_reg * sigma_reg;

    assign lane_ctl.start = state_reg == S_LSTART;
    assign lane_ctl.axis  = axis_reg;

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_lane
        gnpf_lane #(
            .LANE_OFFSET(gi - 1)
        ) u_lane (
            .clk  (clk),
            .rst_n(rst_n),
            .ctl  (lane_ctl),
            .mu   (mu_reg),
            .amp  (amp_reg),
            .rs2  (rs2_reg),
            .g    (lane_g[gi]),
            .jac  (lane_jac[gi]),
            .done (lane_done_vec[gi])
        );
        assign lane_f[gi] = lane_g[gi] - smp_reg[gi];
    end

    assign lane_done_all = lane_done_reg | lane_done_vec;

    // The same divider serves the inverse variance and both step sizes.
    always_comb
    begin
        div_req.start = accept || state_reg == S_DSTART;
        if (state_reg == S_IDLE)
        begin
            div_req.dividend = RS2_NUM;
            div_req.divisor  = {18'd0, sig_sq};
        end
        else if (axis_reg)
        begin
            div_req.dividend = 32'd0 - jf_reg;
            div_req.divisor  = asr32(jj_reg, GAIN_FRAC_BITS);
        end
        else
        begin
            div_req.dividend = (32'd0 - jf_reg) << POS_FRAC_BITS;
            div_req.divisor  = jj_reg;
        end
    end

    gnpf_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    // Merge multiplier: J'J and J'f terms one per cycle, then the squared step.
    always_comb
    begin
        case (state_reg)
            S_DOT:
            begin
                case (cnt_reg)
                    3'd0:
                    begin
                        dot_a = lane_jac[0];
                        dot_b = lane_jac[0];
                    end
                    3'd1:
                    begin
                        dot_a = lane_jac[1];
                        dot_b = lane_jac[1];
                    end
                    3'd2:
                    begin
                        dot_a = lane_jac[2];
                        dot_b = lane_jac[2];
                    end
                    3'd3:
                    begin
                        dot_a = lane_jac[0];
                        dot_b = lane_f[0];
                    end
                    3'd4:
                    begin
                        dot_a = lane_jac[1];
                        dot_b = lane_f[1];
                    end
                    3'd5:
                    begin
                        dot_a = lane_jac[2];
                        dot_b = lane_f[2];
                    end
                    default:
                    begin
                        dot_a = 32'd0;
                        dot_b = 32'd0;
                    end
                endcase
            end
            S_NORM:
            begin
                dot_a = dp_reg;
                dot_b = dp_reg;
            end
            default:
            begin
                dot_a = 32'd0;
                dot_b = 32'd0;
            end
        endcase
    end

    assign mprod  = dot_a * dot_b;
    assign mu_sum = mu_reg + div_rsp.quotient;

    always_comb
    begin
        if ($signed(mu_sum) >= MU_LIMIT)
            mu_clamped = MU_LIMIT;
        else if ($signed(mu_sum) <= -MU_LIMIT)
            mu_clamped = 32'd0 - MU_LIMIT;
        else
            mu_clamped = mu_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sigma_reg     <= SIGMA_RESET;
            maxit_reg     <= MAXIT_RESET;
            axis_reg      <= 1'b0;
            cnt_reg       <= 3'd0;
            lane_done_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SIGMA: sigma_reg <= cfg_data;
                    CFG_MAXIT: maxit_reg <= cfg_data[5:0];
                endcase
            end

            if (state_reg == S_FIN && can_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_RS2;
                end
                S_RS2:
                begin
                    if (div_rsp.done)
                    begin
                        axis_reg  <= 1'b0;
                        state_reg <= S_LSTART;
                    end
                end
                S_LSTART:
                begin
                    lane_done_reg <= 3'd0;
                    state_reg     <= S_LANE;
                end
                S_LANE:
                begin
                    // Lanes may finish on different cycles; hold each flag.
                    lane_done_reg <= lane_done_all;
                    if (&lane_done_all)
                    begin
                        cnt_reg   <= 3'd0;
                        state_reg <= S_DOT;
                    end
                end
                S_DOT:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd6)
                        state_reg <= S_DSTART;
                end
                S_DSTART: state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_rsp.done)
                        state_reg <= axis_reg ? S_CHECK : S_NORM;
                end
                S_NORM:
                begin
                    axis_reg  <= 1'b1;
                    state_reg <= S_LSTART;
                end
                S_CHECK:
                begin
                    if (iter_reg < maxit_reg && $signed(dpnorm_reg) > DPNORM_STOP)
                    begin
                        axis_reg  <= 1'b0;
                        state_reg <= S_LSTART;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (can_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    smp_reg[0] <= {{16{sample_left[15]}}, sample_left};
                    smp_reg[1] <= {{16{sample_mid[15]}}, sample_mid};
                    smp_reg[2] <= {{16{sample_right[15]}}, sample_right};
                    center_reg <= center_index;
                end
            end
            S_RS2:
            begin
                if (div_rsp.done)
                begin
                    rs2_reg  <= div_rsp.quotient;
                    mu_reg   <= 32'd0;
                    amp_reg  <= smp_reg[1] + 32'd1;
                    iter_reg <= 6'd0;
                end
            end
            S_LANE:
            begin
                jj_reg <= 32'd0;
                jf_reg <= 32'd0;
            end
            S_DOT:
            begin
                mprod_reg <= mprod;
                if (cnt_reg != 3'd0)
                begin
                    if (cnt_reg <= 3'd3)
                        jj_reg <= jj_reg + mprod_reg;
                    else
                        jf_reg <= jf_reg + mprod_reg;
                end
            end
            S_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (axis_reg)
                    begin
                        amp_reg  <= amp_reg + div_rsp.quotient;
                        iter_reg <= iter_reg + 6'd1;
                    end
                    else
                    begin
                        mu_reg <= mu_clamped;
                        dp_reg <= div_rsp.quotient;
                    end
                end
            end
            S_NORM: dpnorm_reg <= mprod;
            S_FIN:
            begin
                if (can_load)
                begin
                    position_reg  <= 16'(mu_reg + ({24'd0, center_reg} << POS_FRAC_BITS));
                    iters_out_reg <= iter_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign position        = position_reg;
    assign iterations_used = iters_out_reg;

    assign div_awaited  = state_reg == S_RS2 || state_reg == S_DWAIT;
    assign mu_step_done = state_reg == S_DWAIT && div_rsp.done && !axis_reg;
    assign mu_in_range  = $signed(mu_reg) <= MU_LIMIT && $signed(mu_reg) >= -MU_LIMIT;

    `GNPF_ASSERT_NOW(a_lane_done_phase, |lane_done_vec, state_reg == S_LANE, "lane done early")
    `GNPF_ASSERT_NOW(a_div_done_phase, div_rsp.done, div_awaited, "divider done unexpectedly")
    `GNPF_ASSERT_NEXT(a_mu_clamped, mu_step_done, mu_in_range, "center offset out of range")

endmodule

[hdl/gnpf_div.sv]
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on gnpf_pkg; a zero divisor returns a zero quotient.
`timescale 1ns / 1ps

module gnpf_div
    import gnpf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvsr_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic [31:0] q_reg;

    logic [32:0] trial;
    logic        fits;
    logic [31:0] rem_next;
    logic [31:0] quo_next;
    logic [31:0] a_mag;
    logic [31:0] b_mag;

    assign a_mag    = req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
    assign b_mag    = req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
    assign trial    = {rem_reg, quo_reg[31]};
    assign fits     = trial >= {1'b0, dvsr_reg};
    assign rem_next = fits ? 32'(trial - {1'b0, dvsr_reg}) : trial[31:0];
    assign quo_next = {quo_reg[30:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= 32'd0;
            quo_reg  <= a_mag;
            dvsr_reg <= b_mag;
            neg_reg  <= req.dividend[31] ^ req.divisor[31];
            zero_reg <= (req.divisor == 32'd0);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (cnt_reg == 5'd31)
                q_reg <= zero_reg ? 32'd0 : (neg_reg ? 32'd0 - quo_next : quo_next);
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

[hdl/gnpf_lane.sv]
// One sample lane: model value and Jacobian of the Gaussian at a fixed offset.
// Depends on gnpf_pkg; one shared 32x32 multiplier is stepped by a sequencer.
`timescale 1ns / 1ps

module gnpf_lane
    import gnpf_pkg::*;
#(
    parameter int LANE_OFFSET = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lane_ctl_t   ctl,
    input  logic [31:0] mu,
    input  logic [31:0] amp,
    input  logic [31:0] rs2,
    output logic [31:0] g,
    output logic [31:0] jac,
    output logic        done
);

    localparam logic [31:0] D_BASE = 32'(LANE_OFFSET * (2 ** POS_FRAC_BITS));

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DD   = 4'd1;
    localparam logic [3:0] ST_URS  = 4'd2;
    localparam logic [3:0] ST_EXP  = 4'd3;
    localparam logic [3:0] ST_HH   = 4'd4;
    localparam logic [3:0] ST_HHH  = 4'd5;
    localparam logic [3:0] ST_DIV3 = 4'd6;
    localparam logic [3:0] ST_TDEM = 4'd7;
    localparam logic [3:0] ST_TMUL = 4'd8;
    localparam logic [3:0] ST_ESET = 4'd9;
    localparam logic [3:0] ST_EAMP = 4'd10;
    localparam logic [3:0] ST_G    = 4'd11;
    localparam logic [3:0] ST_J    = 4'd12;
    localparam logic [3:0] ST_JAC  = 4'd13;

    logic [3:0]  step_reg;
    logic        done_reg;
    logic        axis_reg;
    logic [31:0] d_reg;
    logic [63:0] m_reg;
    logic [31:0] h_reg;
    logic        pos_reg;
    logic [31:0] tab_reg;
    logic [31:0] t2_reg;
    logic        neg3_reg;
    logic [31:0] dem_reg;
    logic [31:0] e_reg;
    logic [31:0] g_reg;
    logic [31:0] jac_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    // Exponential range reduction.
    logic [31:0] u;
    logic [31:0] mx;
    logic [31:0] pr;
    logic [31:0] pl;
    logic [31:0] br;
    logic [31:0] bl;
    logic [31:0] cmp;
    logic        take_left;
    logic [31:0] h_sel;
    logic [31:0] p_sel;
    logic [31:0] tab_sel;

    // Cubic term and polynomial sum.
    logic [31:0] v3;
    logic [31:0] v3_mag;
    logic [31:0] q3;
    logic [31:0] q3_s;
    logic [31:0] t1;
    logic [31:0] t3;
    logic [31:0] dem;

    assign u         = asr32(m_reg[31:0], GAIN_FRAC_BITS + 1);
    assign mx        = 32'd0 - u;
    assign pr        = 32'd0 - asr32(u, POS_FRAC_BITS);
    assign pl        = pr - 32'd1;
    assign br        = 32'd0 - ((32'd0 - pr) << POS_FRAC_BITS);
    assign bl        = 32'd0 - ((32'd0 - pl) << POS_FRAC_BITS);
    assign cmp       = bl - (mx << 1) + br;
    assign take_left = $signed(cmp) > 0;
    assign h_sel     = take_left ? mx - bl : br - mx;
    assign p_sel     = take_left ? pl : pr;
    assign tab_sel   = exp_tab_at(32'd0 - p_sel);

    assign v3     = asr32(m_reg[31:0], 2 * POS_FRAC_BITS + 1);
    assign v3_mag = v3[31] ? 32'd0 - v3 : v3;
    assign q3     = {1'b0, m_reg[63:33]};
    assign q3_s   = neg3_reg ? 32'd0 - q3 : q3;
    assign t3     = pos_reg ? q3_s : 32'd0 - q3_s;
    assign t1     = pos_reg ? h_reg : 32'd0 - h_reg;
    assign dem    = (32'd1 << POS_FRAC_BITS) + t1 + t2_reg + t3;

    always_comb
    begin
        case (step_reg)
            ST_DD:
            begin
                mul_a = d_reg;
                mul_b = d_reg;
            end
            ST_URS:
            begin
                mul_a = asr32(m_reg[31:0], POS_FRAC_BITS);
                mul_b = rs2;
            end
            ST_HH:
            begin
                mul_a = h_reg;
                mul_b = h_reg;
            end
            ST_HHH:
            begin
                mul_a = m_reg[31:0];
                mul_b = h_reg;
            end
            ST_DIV3:
            begin
                mul_a = v3_mag;
                mul_b = ONE_THIRD_RECIP;
            end
            ST_TMUL:
            begin
                mul_a = tab_reg;
                mul_b = dem_reg;
            end
            ST_EAMP:
            begin
                mul_a = e_reg;
                mul_b = amp;
            end
            ST_G:
            begin
                mul_a = d_reg;
                mul_b = rs2;
            end
            ST_J:
            begin
                mul_a = asr32(m_reg[31:0], GAIN_FRAC_BITS);
                mul_b = g_reg;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (step_reg)
                ST_IDLE:
                begin
                    if (ctl.start)
                        step_reg <= ST_DD;
                end
                ST_DD:   step_reg <= ST_URS;
                ST_URS:  step_reg <= ST_EXP;
                ST_EXP:
                begin
                    // Exact or out-of-range arguments skip the Taylor expansion.
                    if ($signed(mx) > 0 || mx == 32'd0
                        || $signed(32'd0 - pr) >= EXP_TABLE_DEPTH || h_sel == 32'd0)
                        step_reg <= ST_EAMP;
                    else
                        step_reg <= ST_HH;
                end
                ST_HH:   step_reg <= ST_HHH;
                ST_HHH:  step_reg <= ST_DIV3;
                ST_DIV3: step_reg <= ST_TDEM;
                ST_TDEM: step_reg <= ST_TMUL;
                ST_TMUL: step_reg <= ST_ESET;
                ST_ESET: step_reg <= ST_EAMP;
                ST_EAMP: step_reg <= ST_G;
                ST_G:
                begin
                    if (axis_reg)
                    begin
                        step_reg <= ST_IDLE;
                        done_reg <= 1'b1;
                    end
                    else
                        step_reg <= ST_J;
                end
                ST_J:    step_reg <= ST_JAC;
                ST_JAC:
                begin
                    step_reg <= ST_IDLE;
                    done_reg <= 1'b1;
                end
                default: step_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= prod;
        case (step_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    d_reg    <= D_BASE - mu;
                    axis_reg <= ctl.axis;
                end
            end
            ST_EXP:
            begin
                h_reg   <= h_sel;
                pos_reg <= take_left;
                tab_reg <= tab_sel;
                if ($signed(mx) > 0)
                    e_reg <= ALL_ONES;
                else if (mx == 32'd0)
                    e_reg <= EXP_ONE;
                else if ($signed(32'd0 - pr) >= EXP_TABLE_DEPTH)
                    e_reg <= 32'd0;
                else
                    e_reg <= tab_sel;
            end
            ST_HHH:  t2_reg   <= asr32(m_reg[31:0], POS_FRAC_BITS + 1);
            ST_DIV3: neg3_reg <= v3[31];
            ST_TDEM: dem_reg  <= dem;
            ST_ESET: e_reg    <= asr32(m_reg[31:0], POS_FRAC_BITS);
            ST_G:
            begin
                g_reg <= asr32(m_reg[31:0], GAIN_FRAC_BITS);
                if (axis_reg)
                    jac_reg <= e_reg;
            end
            ST_JAC:  jac_reg <= asr32(m_reg[31:0], POS_FRAC_BITS);
            default:
            begin
            end
        endcase
    end

    assign g    = g_reg;
    assign jac  = jac_reg;
    assign done = done_reg;

endmodule
